// ----- hdl/periodic_message_scheduler_top_assert.svh -----
// assertion macros for the periodic message scheduler
// expects clk and rst_n in the scope of each use
`ifndef PERIODIC_MESSAGE_SCHEDULER_TOP_ASSERT_SVH
`define PERIODIC_MESSAGE_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define PMS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("scheduler assertion failed");

// next-cycle implication
`define PMS_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("scheduler assertion failed");

// invariant
`define PMS_ASSERT_ALW(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("scheduler assertion failed");

`endif

// ----- hdl/pms_pkg.sv -----
// types and constants of the periodic message scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

  localparam int TIME_W = 32;
  localparam int SLOT_W = 5;
  localparam int MASK_W = 20;
  localparam logic [TIME_W-1:0] DELAY_NONE = {TIME_W{1'b1}};

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_SET  = 1'b1
  } func_t;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period_ms;
    logic [TIME_W-1:0] now_ms;
    logic [MASK_W-1:0] accept_mask;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] fired_slot;
    logic              fired;
    logic              sent_ok;
    logic [TIME_W-1:0] next_delay_ms;
    logic              last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic pwrite;
    logic rd;
    logic sub;
    logic eval;
    logic inc;
    logic load_ack;
    logic load_fire;
    logic load_fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic set_req;
    logic can_load;
    logic fire;
    logic idx_last;
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/pms_dp.sv -----
// datapath: slot tables, elapsed/delay arithmetic, minimum and output register
// depends on pms_pkg
`timescale 1ns / 1ps
`default_nettype none

module pms_dp
  import pms_pkg::*;
#(
  parameter int NUM_SLOTS = 20
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire cmd_t      cmd,
  output status_t        status,
  input  wire logic      out_ready,
  output logic           out_valid,
  output out_item_t      out_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  in_item_t            in_r;
  logic [TIME_W-1:0]   pmem [NUM_SLOTS];
  logic [TIME_W-1:0]   lmem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] pvalid_r;
  logic [NUM_SLOTS-1:0] lvalid_r;
  logic [TIME_W-1:0]   p_rd_r;
  logic [TIME_W-1:0]   l_rd_r;
  logic [TIME_W-1:0]   elapsed_r;
  logic [TIME_W-1:0]   d_r;
  logic                dv_r;
  logic [TIME_W-1:0]   min_r;
  logic [TIME_W-1:0]   min_nxt;
  logic                fire_r;
  logic                ok_r;
  logic [IDX_W-1:0]    idx_r;
  logic                out_valid_r;
  out_item_t           out_r;

  logic [IDX_W+SLOT_W-1:0] slot_ext;
  logic [IDX_W+SLOT_W-1:0] idx_ext;
  logic                    slot_in_range;
  logic [MASK_W-1:0]       acc_sh;
  logic                    fire;
  logic                    ok;
  logic                    enabled;
  logic [TIME_W-1:0]       d_raw;
  logic [TIME_W-1:0]       d_clamp;

  assign slot_ext      = {{IDX_W{1'b0}}, in_r.slot};
  assign idx_ext       = {{SLOT_W{1'b0}}, idx_r};
  assign slot_in_range = slot_ext < (IDX_W+SLOT_W)'(NUM_SLOTS);

  // slots past the mask width shift out to zero, so they are never accepted
  assign acc_sh  = in_r.accept_mask >> idx_r;
  assign ok      = acc_sh[0];
  assign enabled = (p_rd_r != '0);
  assign fire    = enabled && (elapsed_r >= p_rd_r);
  // after an update last equals now, so the delay is the full period
  assign d_raw   = (fire && ok) ? p_rd_r : (p_rd_r - elapsed_r);
  assign d_clamp = d_raw[TIME_W-1] ? '0 : d_raw;

  // running minimum including a delay still in flight from the last evaluation
  assign min_nxt = (dv_r && (d_r < min_r)) ? d_r : min_r;

  assign status.set_req  = (in_data.func == FUNC_SET);
  assign status.can_load = !out_valid_r || out_ready;
  assign status.fire     = fire;
  assign status.idx_last = (idx_r == IDX_W'(NUM_SLOTS - 1));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // tables, written and read in clocked blocks
  always_ff @(posedge clk) begin
    if (cmd.pwrite && slot_in_range) begin
      pmem[slot_ext[IDX_W-1:0]] <= in_r.period_ms;
    end
    if (cmd.eval && fire && ok) begin
      lmem[idx_r] <= in_r.now_ms;
    end
    if (cmd.rd) begin
      p_rd_r <= pvalid_r[idx_r] ? pmem[idx_r] : '0;
      l_rd_r <= lvalid_r[idx_r] ? lmem[idx_r] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r    <= '0;
      lvalid_r    <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.pwrite && slot_in_range) begin
        pvalid_r[slot_ext[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd.eval && fire && ok) begin
        lvalid_r[idx_r] <= 1'b1;
      end
      dv_r <= cmd.eval && enabled;
      if (cmd.load_ack || cmd.load_fire || cmd.load_fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      in_r  <= in_data;
      idx_r <= '0;
      min_r <= DELAY_NONE;
    end else begin
      if (cmd.inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      min_r <= min_nxt;
    end
    if (cmd.sub) begin
      elapsed_r <= in_r.now_ms - l_rd_r;
    end
    if (cmd.eval) begin
      fire_r <= fire;
      ok_r   <= ok;
      d_r    <= d_clamp;
    end
    if (cmd.load_ack) begin
      out_r.fired_slot    <= in_r.slot;
      out_r.fired         <= 1'b0;
      out_r.sent_ok       <= 1'b0;
      out_r.next_delay_ms <= '0;
      out_r.last          <= 1'b1;
    end else if (cmd.load_fire) begin
      out_r.fired_slot    <= idx_ext[SLOT_W-1:0];
      out_r.fired         <= fire_r;
      out_r.sent_ok       <= ok_r;
      out_r.next_delay_ms <= '0;
      out_r.last          <= 1'b0;
    end else if (cmd.load_fin) begin
      out_r.fired_slot    <= '0;
      out_r.fired         <= 1'b0;
      out_r.sent_ok       <= 1'b0;
      out_r.next_delay_ms <= min_nxt;
      out_r.last          <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pms_ctrl.sv -----
// controller: sequences set-period items and the slot walk of a tick
// depends on pms_pkg
`timescale 1ns / 1ps
`default_nettype none

module pms_ctrl
  import pms_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACK,
    S_RD,
    S_SUB,
    S_EVAL,
    S_OUT,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = status.set_req ? S_ACK : S_RD;
        end
      end
      S_ACK: begin
        if (status.can_load) begin
          cmd.pwrite   = 1'b1;
          cmd.load_ack = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (status.fire) begin
          state_nxt = S_OUT;
        end else begin
          cmd.inc   = !status.idx_last;
          state_nxt = status.idx_last ? S_FIN : S_RD;
        end
      end
      S_OUT: begin
        if (status.can_load) begin
          cmd.load_fire = 1'b1;
          cmd.inc       = !status.idx_last;
          state_nxt     = status.idx_last ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        // the minimum is taken from min_nxt, which still adds in the delay registered by the last evaluation
        if (status.can_load) begin
          cmd.load_fin = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/periodic_message_scheduler_top.sv -----
// set-period item: accepted, then the period written and the acknowledgment loaded once the output register has room.
// tick item: per slot a table read, the elapsed time and a compare, plus a result load per fired slot,
// after the accept and before the final result that carries the minimum delay.
// one item at a time; the next item is taken while the last result waits in the output register.
// synchronous active-low reset disables all slots and zeroes all last-sent times at once.
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_message_scheduler_top_assert.svh"

module periodic_message_scheduler_top
  import pms_pkg::*;
#(
  parameter int NUM_AXES          = 2,
  parameter int CHANNELS_PER_AXIS = 10
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  localparam int NUM_SLOTS = NUM_AXES * CHANNELS_PER_AXIS;

  cmd_t    cmd;
  status_t status;

  pms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pms_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `PMS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `PMS_ASSERT_IMP(a_load_needs_room, cmd.load_ack || cmd.load_fire || cmd.load_fin, status.can_load)
  `PMS_ASSERT_ALW(a_one_load, $onehot0({cmd.load_ack, cmd.load_fire, cmd.load_fin}))
  `PMS_ASSERT_NXT(a_fire_result_shape, cmd.load_fire, out_valid && !out_data.last && out_data.fired)

endmodule

`default_nettype wire

// ----- tb/tb_periodic_message_scheduler_top.sv -----
// self-checking testbench for periodic_message_scheduler_top
// keeps its own period and last-sent tables and checks every result item in order
// depends on pms_pkg and the scheduler rtl
`timescale 1ns / 1ps

module tb_periodic_message_scheduler_top;
  import pms_pkg::*;

  localparam int NUM_SLOTS = 20;
  localparam int DRAIN_CYCLES = 120;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  periodic_message_scheduler_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scheduler state as the testbench sees it
  logic [TIME_W-1:0] period_tbl [NUM_SLOTS];
  logic [TIME_W-1:0] last_tbl [NUM_SLOTS];

  in_item_t  send_q [$];
  out_item_t sched_results_q [$];

  int unsigned n_items_total = 0;
  int unsigned n_accepted = 0;
  int unsigned n_ticks = 0;
  int unsigned n_writes = 0;
  int unsigned n_fired = 0;
  int unsigned n_sent = 0;
  int unsigned n_mismatch = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;

  // bursts come and go in stretches, and stop near the end of the run
  function automatic bit bursts_allowed(int unsigned remaining);
    return (remaining > 25) && ((remaining / 16) % 3 != 0);
  endfunction

  function automatic void schedule_step(in_item_t it);
    out_item_t         r;
    logic [TIME_W-1:0] p;
    logic [TIME_W-1:0] d;
    logic [TIME_W-1:0] soonest;
    logic              ok;
    soonest = DELAY_NONE;
    if (it.func == FUNC_SET) begin
      if (it.slot < NUM_SLOTS) period_tbl[it.slot] = it.period_ms;
      r = '0;
      r.fired_slot = it.slot;
      r.last = 1'b1;
      sched_results_q.push_back(r);
      n_writes++;
      return;
    end
    n_ticks++;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      p = period_tbl[i];
      if (p == '0) continue;
      d = it.now_ms - last_tbl[i];
      if (d >= p) begin
        ok = it.accept_mask[i];
        if (ok) last_tbl[i] = it.now_ms;
        r = '0;
        r.fired_slot = SLOT_W'(i);
        r.fired = 1'b1;
        r.sent_ok = ok;
        sched_results_q.push_back(r);
      end
      // wrapped distance to the next due time, overdue reads as zero
      d = last_tbl[i] + p - it.now_ms;
      if (d[TIME_W-1]) d = '0;
      if (d < soonest) soonest = d;
    end
    r = '0;
    r.next_delay_ms = soonest;
    r.last = 1'b1;
    sched_results_q.push_back(r);
  endfunction

  function automatic void compare_result(out_item_t got);
    out_item_t want;
    if (sched_results_q.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("%0t: unexpected result slot=%0d fired=%0b ok=%0b delay=%0h last=%0b",
                 $realtime, got.fired_slot, got.fired, got.sent_ok, got.next_delay_ms,
                 got.last);
      return;
    end
    want = sched_results_q.pop_front();
    if (got.fired_slot !== want.fired_slot || got.fired !== want.fired ||
        got.sent_ok !== want.sent_ok || got.next_delay_ms !== want.next_delay_ms ||
        got.last !== want.last) begin
      n_mismatch++;
      if (n_mismatch <= 10) begin
        $write("%0t: exp slot=%0d fired=%0b ok=%0b delay=%0h last=%0b, ",
               $realtime, want.fired_slot, want.fired, want.sent_ok, want.next_delay_ms,
               want.last);
        $display("got slot=%0d fired=%0b ok=%0b delay=%0h last=%0b",
                 got.fired_slot, got.fired, got.sent_ok, got.next_delay_ms, got.last);
      end
    end
    if (got.fired) begin
      n_fired++;
      if (got.sent_ok) n_sent++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        period_tbl[i] = '0;
        last_tbl[i] = '0;
      end
    end else begin
      if (in_valid && in_ready) begin
        schedule_step(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (send_q.size() > 0) begin
          in_data <= send_q.pop_front();
          in_valid <= 1'b1;
          if (bursts_allowed(send_q.size()) && $urandom_range(0, 3) == 0)
            in_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) compare_result(out_data);
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if (bursts_allowed(send_q.size()) && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_set(logic [SLOT_W-1:0] sl, logic [TIME_W-1:0] per);
    in_item_t it;
    it.func = FUNC_SET;
    it.slot = sl;
    it.period_ms = per;
    it.now_ms = $urandom;
    it.accept_mask = MASK_W'($urandom);
    send_q.push_back(it);
  endtask

  task automatic push_tick(logic [TIME_W-1:0] t_now, logic [MASK_W-1:0] msk);
    in_item_t it;
    it.func = FUNC_TICK;
    it.slot = SLOT_W'($urandom);
    it.period_ms = $urandom;
    it.now_ms = t_now;
    it.accept_mask = msk;
    send_q.push_back(it);
  endtask

  initial begin
    logic [TIME_W-1:0] t_now;
    logic [TIME_W-1:0] per;
    logic [MASK_W-1:0] msk;
    logic [SLOT_W-1:0] sl;

    // directed: empty table, out-of-range writes, extreme periods, wraparound
    push_tick(32'h0, '0);
    push_set(5'd0, 32'd1);
    push_set(5'd19, 32'hFFFF_FFFF);
    push_set(5'd5, 32'h8000_0000);
    push_set(5'd31, 32'd5);
    push_set(5'd20, 32'd7);
    push_tick(32'h0, '1);
    push_tick(32'h1, '0);
    push_tick(32'h2, '1);
    push_tick(32'h8000_0002, 20'h00020);
    push_tick(32'hFFFF_FFFF, '1);
    push_tick(32'h3, '1);
    push_set(5'd0, 32'h0);
    push_set(5'd10, 32'd2);
    push_tick(32'h3, 20'hAAAAA);
    push_tick(32'h5, 20'h55555);

    // every slot enabled with a short period, then one tick at a random time with every slot accepting
    for (int i = 0; i < NUM_SLOTS; i++) push_set(SLOT_W'(i), $urandom_range(1, 8));
    t_now = $urandom;
    push_tick(t_now, '1);

    for (int k = 0; k < 145; k++) begin
      if (k == 80) t_now = 32'hFFFF_FFC0;
      if ($urandom_range(0, 99) < 35) begin
        sl = ($urandom_range(0, 6) == 0) ? SLOT_W'($urandom_range(20, 31))
                                         : SLOT_W'($urandom_range(0, 19));
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: per = $urandom_range(1, 40);
          5: per = '0;
          6: per = $urandom;
          7: per = 32'h8000_0000 + $urandom_range(0, 15) - 8;
          default: per = 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
        push_set(sl, per);
      end else begin
        case ($urandom_range(0, 15))
          0: t_now = $urandom;
          1: t_now += $urandom;
          default: t_now += $urandom_range(0, 25);
        endcase
        case ($urandom_range(0, 3))
          0: msk = '1;
          1: msk = MASK_W'($urandom & $urandom);
          default: msk = MASK_W'($urandom);
        endcase
        push_tick(t_now, msk);
      end
    end
    n_items_total = send_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_items_total) @(posedge clk);
    while (sched_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d ticks and %0d period writes accepted, %0d slot firings (%0d sent)",
             n_ticks, n_writes, n_fired, n_sent);
    $display("run: %0d mismatching result items", n_mismatch);
    if (n_mismatch == 0 && sched_results_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout: %0d of %0d items accepted, %0d results outstanding",
             n_accepted, n_items_total, sched_results_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- periodic_message_scheduler_top.f -----
+incdir+hdl
hdl/pms_pkg.sv
hdl/pms_dp.sv
hdl/pms_ctrl.sv
hdl/periodic_message_scheduler_top.sv
tb/tb_periodic_message_scheduler_top.sv
